[sv/ppma_pkg.sv]
`default_nettype none
package ppma_pkg;

	localparam int NUM_ANODES    = 240;
	localparam int NUM_TIME_BINS = 128;
	localparam int SAMPLE_BITS   = 8;
	localparam int COUNT_BITS    = 16;
	localparam int NPIX          = NUM_ANODES * NUM_TIME_BINS;
	localparam int PIX_W         = $clog2(NPIX);
	localparam int SUM_W         = 24;
	localparam int SQ_W          = 32;
	localparam int DVD_W         = SQ_W + 16;
	localparam int STEP_W        = $clog2(DVD_W);

	localparam logic [1:0] KIND_FILL     = 2'd0;
	localparam logic [1:0] KIND_QUERY    = 2'd1;
	localparam logic [1:0] KIND_FILL_ALL = 2'd2;
	localparam logic [1:0] KIND_CLEAR    = 2'd3;

	typedef struct packed {
		logic [COUNT_BITS-1:0] cnt;
		logic [SUM_W-1:0]      sum;
		logic [SQ_W-1:0]       sq;
	} entry_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_UPD,
		ST_SW_RD,
		ST_SW_WR,
		ST_CLR,
		ST_DIV,
		ST_DIVX,
		ST_MUL,
		ST_VAR,
		ST_SQRT,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

[sv/pixel_pedestal_moment_accumulator_unit.sv]
// Per-pixel moment accumulator (count, sum, sum of squares) over a
// 240 x 128 pixel array held in one 72-bit wide memory with one read and one write port.
// Input channel: in_valid/in_stall with kind, anode, time_bin, sample.
// Output channel: out_valid/out_stall; exactly one result per input item.
// Fill and query: read, update (fill writes back), then, unless the count is
// zero, two restoring divisions on one shared divider (mean, mean of squares),
// one 24x24 multiply and a 16-step square root.
// Bad address: straight to the result. Fill-all: per pixel a read then a
// write. Clear: one cycle per pixel.
// in_stall is high while an item is in work; one item at a time.
// After reset a clearing pass writes zeros to all 30720 entries, one per
// cycle; in_stall stays high during it.
// The result sits in an output register; a new item may be taken while it
// waits. A finished item whose result cannot be placed because the output
// register is still stalled waits in its last state.
`default_nettype none
module pixel_pedestal_moment_accumulator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  anode,
	input  wire logic [6:0]  time_bin,
	input  wire logic [7:0]  sample,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      pixel_count,
	output logic [23:0]      pixel_sum,
	output logic [31:0]      pixel_sum_sq,
	output logic [15:0]      mean_q8,
	output logic [15:0]      rms_q8,
	output logic             saturated,
	output logic             address_error
);
	import ppma_pkg::*;

	state_t state_q, state_d;

	entry_t mem [NPIX];
	entry_t rd_q;
	logic             mem_we;
	logic [PIX_W-1:0] mem_raddr, mem_waddr;
	entry_t           mem_wdata;

	logic [PIX_W-1:0]       idx_q, pix_q;
	logic [1:0]             kind_q;
	logic [SAMPLE_BITS-1:0] x_q;
	logic                   aerr_q, sat_q;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]        sq_q;
	logic [DVD_W-1:0]       dvd_q;
	logic [COUNT_BITS-1:0]  rem_q;
	logic [STEP_W-1:0]      step_q;
	logic                   sel_q;
	logic [23:0]            m_q;
	logic [31:0]            msq_q, m2_q, v_q, res_q, bit_q;
	logic                   out_valid_q;

	logic                   accept, bad_addr, done_go, last_idx;
	logic [PIX_W-1:0]       pix_in;
	logic [SUM_W:0]         sn;
	logic [SQ_W:0]          qn;
	logic [2*SAMPLE_BITS-1:0] xx;
	logic                   drop;
	logic [COUNT_BITS:0]    trial, tdiff;
	logic                   ge;
	logic [47:0]            mm;
	logic [31:0]            rb;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign done_go  = !out_valid_q || !out_stall;
	assign last_idx = (idx_q == PIX_W'(NPIX - 1));
	assign out_valid = out_valid_q;

	assign bad_addr = (anode == 8'd0) || (32'(anode) > NUM_ANODES)
		|| (32'(time_bin) >= NUM_TIME_BINS);
	assign pix_in = PIX_W'((32'(anode) - 32'd1) * NUM_TIME_BINS + 32'(time_bin));

	// fill update, shared by single and all-pixel fill
	assign xx   = x_q * x_q;
	assign sn   = {1'b0, rd_q.sum} + (SUM_W+1)'(x_q);
	assign qn   = {1'b0, rd_q.sq} + (SQ_W+1)'(xx);
	assign drop = (rd_q.cnt == {COUNT_BITS{1'b1}}) || sn[SUM_W] || qn[SQ_W];

	// divider step
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, cnt_q};
	assign tdiff = trial - {1'b0, cnt_q};

	assign mm = m_q * m_q;
	assign rb = res_q + bit_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT, ST_CLR: begin
				if (last_idx) state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_CLEAR:    state_d = ST_CLR;
						KIND_FILL_ALL: state_d = ST_SW_RD;
						default:       state_d = bad_addr ? ST_DONE : ST_RD;
					endcase
				end
			end
			ST_RD:    state_d = ST_UPD;
			ST_UPD: begin
				if ((kind_q == KIND_FILL) && !drop) begin
					state_d = ST_DIV;
				end else begin
					state_d = (rd_q.cnt == '0) ? ST_DONE : ST_DIV;
				end
			end
			ST_SW_RD: state_d = ST_SW_WR;
			ST_SW_WR: state_d = last_idx ? ST_DONE : ST_SW_RD;
			ST_DIV:   if (step_q == STEP_W'(DVD_W - 1)) state_d = ST_DIVX;
			ST_DIVX:  state_d = sel_q ? ST_MUL : ST_DIV;
			ST_MUL:   state_d = ST_VAR;
			ST_VAR:   state_d = ST_SQRT;
			ST_SQRT:  if (bit_q == 32'd1) state_d = ST_DONE;
			ST_DONE:  if (done_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		mem_raddr = (state_q == ST_SW_RD) ? idx_q : pix_q;
		case (state_q)
			ST_INIT, ST_CLR: mem_we = 1'b1;
			ST_UPD: begin
				mem_we    = (kind_q == KIND_FILL) && !drop;
				mem_waddr = pix_q;
				mem_wdata = '{cnt: rd_q.cnt + 1'b1, sum: sn[SUM_W-1:0], sq: qn[SQ_W-1:0]};
			end
			ST_SW_WR: begin
				mem_we    = !drop;
				mem_wdata = '{cnt: rd_q.cnt + 1'b1, sum: sn[SUM_W-1:0], sq: qn[SQ_W-1:0]};
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_CLR || state_q == ST_SW_WR) begin
				idx_q <= last_idx ? '0 : idx_q + 1'b1;
			end
			if (state_q == ST_DONE && done_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q <= kind;
					pix_q  <= pix_in;
					x_q    <= sample[SAMPLE_BITS-1:0];
					aerr_q <= (kind == KIND_FILL || kind == KIND_QUERY) && bad_addr;
					sat_q  <= 1'b0;
					cnt_q  <= '0;
					sum_q  <= '0;
					sq_q   <= '0;
					m_q    <= '0;
					res_q  <= '0;
				end
			end
			ST_UPD: begin
				if ((kind_q == KIND_FILL) && !drop) begin
					cnt_q <= rd_q.cnt + 1'b1;
					sum_q <= sn[SUM_W-1:0];
					sq_q  <= qn[SQ_W-1:0];
					dvd_q <= DVD_W'({sn[SUM_W-1:0], 16'd0});
				end else begin
					cnt_q <= rd_q.cnt;
					sum_q <= rd_q.sum;
					sq_q  <= rd_q.sq;
					dvd_q <= DVD_W'({rd_q.sum, 16'd0});
				end
				sat_q  <= (kind_q == KIND_FILL) && drop;
				rem_q  <= '0;
				step_q <= '0;
				sel_q  <= 1'b0;
			end
			ST_SW_WR: if (drop) sat_q <= 1'b1;
			ST_DIV: begin
				rem_q  <= ge ? tdiff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
				dvd_q  <= {dvd_q[DVD_W-2:0], ge};
				step_q <= step_q + 1'b1;
			end
			ST_DIVX: begin
				if (!sel_q) begin
					m_q    <= dvd_q[23:0];
					dvd_q  <= {sq_q, 16'd0};
					rem_q  <= '0;
					step_q <= '0;
					sel_q  <= 1'b1;
				end else begin
					msq_q <= dvd_q[31:0];
				end
			end
			ST_MUL: m2_q <= mm[47:16];
			ST_VAR: begin
				v_q   <= (msq_q > m2_q) ? (msq_q - m2_q) : '0;
				res_q <= '0;
				bit_q <= 32'h4000_0000;
			end
			ST_SQRT: begin
				if (v_q >= rb) begin
					v_q   <= v_q - rb;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DONE: begin
				if (done_go) begin
					pixel_count   <= cnt_q;
					pixel_sum     <= sum_q;
					pixel_sum_sq  <= sq_q;
					mean_q8       <= m_q[23:8];
					rms_q8        <= res_q[15:0];
					saturated     <= sat_q;
					address_error <= aerr_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[sim/ppma_checker.sv]
`default_nettype none
module ppma_checker
	import ppma_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  anode,
	input  wire logic [6:0]  time_bin,
	input  wire logic [7:0]  sample,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [15:0] pixel_count,
	input  wire logic [23:0] pixel_sum,
	input  wire logic [31:0] pixel_sum_sq,
	input  wire logic [15:0] mean_q8,
	input  wire logic [15:0] rms_q8,
	input  wire logic        saturated,
	input  wire logic        address_error,
	output int               fail_count,
	output int               pending
);

	typedef struct {
		logic [15:0] cnt;
		logic [23:0] sum;
		logic [31:0] sq;
		logic [15:0] mean;
		logic [15:0] rms;
		logic        sat;
		logic        aerr;
	} moments_t;

	localparam longint unsigned CNT_LIMIT = (64'd1 << COUNT_BITS) - 1;
	localparam longint unsigned SUM_LIMIT = 64'hFF_FFFF;
	localparam longint unsigned SQ_LIMIT  = 64'hFFFF_FFFF;

	logic [COUNT_BITS-1:0] cnt_mem [NPIX];
	logic [SUM_W-1:0]      sum_mem [NPIX];
	logic [SQ_W-1:0]       sq_mem  [NPIX];
	moments_t              expected_q [$];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// returns 1 when the fill is dropped
	function automatic bit add_to_pixel(int p, longint unsigned x);
		longint unsigned n, s, q;
		n = 64'(cnt_mem[p]);
		s = 64'(sum_mem[p]) + x;
		q = 64'(sq_mem[p]) + x * x;
		if (n >= CNT_LIMIT || s > SUM_LIMIT || q > SQ_LIMIT)
			return 1'b1;
		cnt_mem[p] = COUNT_BITS'(n + 1);
		sum_mem[p] = SUM_W'(s);
		sq_mem[p]  = SQ_W'(q);
		return 1'b0;
	endfunction

	function automatic moments_t pixel_moments(int p);
		moments_t r;
		longint unsigned n, s, q, m, msq, m2, v, mn, rm;
		n = 64'(cnt_mem[p]);
		s = 64'(sum_mem[p]);
		q = 64'(sq_mem[p]);
		mn = 0;
		rm = 0;
		if (n != 0) begin
			m   = (s << 16) / n;
			msq = (q << 16) / n;
			m2  = (m * m) >> 16;
			v   = (msq > m2) ? msq - m2 : 0;
			mn  = (s << 8) / n;
			rm  = int_sqrt(v);
			if (mn > 16'hFFFF) mn = 16'hFFFF;
			if (rm > 16'hFFFF) rm = 16'hFFFF;
		end
		r.cnt  = 16'(n);
		r.sum  = 24'(s);
		r.sq   = 32'(q);
		r.mean = 16'(mn);
		r.rms  = 16'(rm);
		r.sat  = 1'b0;
		r.aerr = 1'b0;
		return r;
	endfunction

	function automatic moments_t predict_item(logic [1:0] k, logic [7:0] a,
			logic [6:0] t, logic [7:0] x);
		moments_t r;
		bit dropped;
		int p;
		r = '{default: '0};
		if (k == KIND_CLEAR) begin
			for (p = 0; p < NPIX; p++) begin
				cnt_mem[p] = '0;
				sum_mem[p] = '0;
				sq_mem[p]  = '0;
			end
		end else if (k == KIND_FILL_ALL) begin
			dropped = 1'b0;
			for (p = 0; p < NPIX; p++)
				if (add_to_pixel(p, 64'(x)))
					dropped = 1'b1;
			r.sat = dropped;
		end else if (a == 0 || a > NUM_ANODES || t >= NUM_TIME_BINS) begin
			r.aerr = 1'b1;
		end else begin
			p = (int'(a) - 1) * NUM_TIME_BINS + int'(t);
			dropped = (k == KIND_FILL) ? add_to_pixel(p, 64'(x)) : 1'b0;
			r = pixel_moments(p);
			r.sat = dropped;
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, longint unsigned got,
			longint unsigned want);
		$display("mismatch %s: got %0d, expected %0d at %0t", field, got, want,
			$realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		for (int p = 0; p < NPIX; p++) begin
			cnt_mem[p] = '0;
			sum_mem[p] = '0;
			sq_mem[p]  = '0;
		end
	end

	always @(posedge clk) begin
		moments_t want;
		if (arst_n && in_valid && !in_stall)
			expected_q.push_back(predict_item(kind, anode, time_bin, sample));
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("result transfer with nothing expected at %0t", $realtime);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (pixel_count !== want.cnt)
					report_mismatch("pixel_count", pixel_count, want.cnt);
				if (pixel_sum !== want.sum)
					report_mismatch("pixel_sum", pixel_sum, want.sum);
				if (pixel_sum_sq !== want.sq)
					report_mismatch("pixel_sum_sq", pixel_sum_sq, want.sq);
				if (mean_q8 !== want.mean)
					report_mismatch("mean_q8", mean_q8, want.mean);
				if (rms_q8 !== want.rms)
					report_mismatch("rms_q8", rms_q8, want.rms);
				if (saturated !== want.sat)
					report_mismatch("saturated", saturated, want.sat);
				if (address_error !== want.aerr)
					report_mismatch("address_error", address_error, want.aerr);
			end
		end
		pending = expected_q.size();
	end

endmodule
`default_nettype wire

[sim/tb_pixel_pedestal_moment_accumulator_unit.sv]
`default_nettype none
module tb_pixel_pedestal_moment_accumulator_unit;
	import ppma_pkg::*;

	localparam int IDLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1330;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = KIND_QUERY;
	logic [7:0]  anode = 8'd1;
	logic [6:0]  time_bin = '0;
	logic [7:0]  sample = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [15:0] pixel_count;
	logic [23:0] pixel_sum;
	logic [31:0] pixel_sum_sq;
	logic [15:0] mean_q8;
	logic [15:0] rms_q8;
	logic        saturated;
	logic        address_error;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	bit          no_gaps = 0;
	int          results_taken = 0;

	logic [7:0]  hot_anode [8];
	logic [6:0]  hot_bin [8];
	logic [7:0]  hot_base [8];

	always #2 clk = ~clk;

	pixel_pedestal_moment_accumulator_unit DUT (.*);

	ppma_checker u_checker (.*);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random stall per transfer, plus occasional long hold-off
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = no_gaps ? 0 : $urandom_range(0, 6);
			if (results_taken == 5 || $urandom_range(0, 255) == 0)
				w = 500;
			repeat (w) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			results_taken++;
		end
	end

	task automatic send_item(logic [1:0] k, logic [7:0] a, logic [6:0] t, logic [7:0] x);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind     <= k;
		anode    <= a;
		time_bin <= t;
		sample   <= x;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random_item(int idx);
		int r, h;
		logic [7:0] x;
		r = $urandom_range(0, 99);
		h = $urandom_range(0, 7);
		x = hot_base[h] + 8'($urandom_range(0, 6)) - 8'd3;
		if ($urandom_range(0, 9) == 0)
			x = 8'($urandom);
		if (idx == 400 || idx == 900)
			send_item(KIND_FILL_ALL, 8'($urandom), 7'($urandom), 8'($urandom));
		else if (idx == 650 || idx == 1200)
			send_item(KIND_CLEAR, 8'($urandom), 7'($urandom), 8'($urandom));
		else if (r < 5)
			send_item(($urandom_range(0, 1) != 0) ? KIND_QUERY : KIND_FILL,
				($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(241, 255)),
				7'($urandom), 8'($urandom));
		else if (r < 15)
			send_item(($urandom_range(0, 1) != 0) ? KIND_QUERY : KIND_FILL,
				8'($urandom_range(1, NUM_ANODES)), 7'($urandom), x);
		else if (r < 65)
			send_item(KIND_FILL, hot_anode[h], hot_bin[h], x);
		else
			send_item(KIND_QUERY, hot_anode[h], hot_bin[h], 8'($urandom));
	endtask

	initial begin
		for (int i = 0; i < 8; i++) begin
			hot_anode[i] = 8'($urandom_range(1, NUM_ANODES));
			hot_bin[i]   = 7'($urandom);
			hot_base[i]  = 8'($urandom_range(3, 252));
		end
		hot_anode[0] = 8'd1;
		hot_bin[0]   = 7'd0;
		hot_anode[1] = 8'd240;
		hot_bin[1]   = 7'd127;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed
		send_item(KIND_QUERY, 8'd1, 7'd0, 8'd0);
		send_item(KIND_FILL, 8'd1, 7'd0, 8'd0);
		send_item(KIND_FILL, 8'd1, 7'd0, 8'd255);
		send_item(KIND_QUERY, 8'd1, 7'd0, 8'd255);
		send_item(KIND_FILL, 8'd240, 7'd127, 8'd255);
		send_item(KIND_FILL, 8'd240, 7'd127, 8'd255);
		send_item(KIND_QUERY, 8'd240, 7'd127, 8'd0);
		send_item(KIND_FILL, 8'd0, 7'd5, 8'd17);
		send_item(KIND_QUERY, 8'd0, 7'd127, 8'd0);
		send_item(KIND_FILL, 8'd241, 7'd0, 8'd99);
		send_item(KIND_QUERY, 8'd255, 7'd64, 8'd255);
		send_item(KIND_FILL, 8'd128, 7'd64, 8'd170);
		send_item(KIND_FILL, 8'd128, 7'd64, 8'd85);
		send_item(KIND_FILL, 8'd128, 7'd64, 8'd1);
		send_item(KIND_QUERY, 8'd128, 7'd64, 8'd0);
		send_item(KIND_FILL_ALL, 8'd0, 7'd0, 8'd200);
		send_item(KIND_QUERY, 8'd128, 7'd64, 8'd0);
		send_item(KIND_QUERY, 8'd77, 7'd33, 8'd0);
		send_item(KIND_CLEAR, 8'd255, 7'd127, 8'd255);
		send_item(KIND_QUERY, 8'd1, 7'd0, 8'd0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_gaps = ((i / 100) % 4) == 3;
			send_random_item(i);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		no_gaps = 0;

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
